/* rtl/core/tvs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tvs_pkg: shared types and constants of the trilinear volume sampler
// Holds the fixed field widths, the operation and register codes, and the
// structs that travel between the front end, the command queue and the back end.
// ----------------------------------------------------------------------------
package tvs_pkg;

	// Operation codes carried in the input tuser bit.
	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	// Configuration register indexes.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_VOL_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VOL_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_VOL_DEPTH  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_Z_SCALE    = 2'd3;

	// Fixed field widths.
	localparam int DIM_W      = 7;
	localparam int ZS_W       = 16;
	localparam int AREA_W     = 2 * DIM_W;
	localparam int CRD_W      = 16;
	localparam int ADDR_IN_W  = 18;
	localparam int VAL_IN_W   = 16;
	localparam int OUT_W      = 24;
	localparam int IN_DATA_W  = 88;
	localparam int ZS_FRAC    = 8;
	localparam int OUT_FRAC   = 8;

	// Upper bounds over the parameter ranges, used to size the command word.
	localparam int MAX_IDX_W  = 24;
	localparam int MAX_FRAC_W = 16;

	localparam int QUEUE_DEPTH = 4;

	localparam logic [DIM_W-1:0] RST_DIM     = 7'd64;
	localparam logic [ZS_W-1:0]  RST_Z_SCALE = 16'd256;

	// Effective volume geometry seen by the datapath.
	typedef struct packed {
		logic [DIM_W-1:0]  w;
		logic [DIM_W-1:0]  h;
		logic [DIM_W-1:0]  d;
		logic [ZS_W-1:0]   zscale;
		logic [AREA_W-1:0] area;
	} cfg_t;

	// One classified command from the front end to the back end.
	typedef struct packed {
		logic                  kind;
		logic                  wr_ok;
		logic                  outside;
		logic                  last;
		logic [MAX_IDX_W-1:0]  idx;
		logic [VAL_IN_W-1:0]   value;
		logic [MAX_FRAC_W-1:0] fx;
		logic [MAX_FRAC_W-1:0] fy;
		logic [MAX_FRAC_W-1:0] fz;
	} cmd_t;

endpackage
`default_nettype wire

/* rtl/core/tvs_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tvs_front: input classification pipeline
// Three stages scale z, test the point against the volume, split coordinates
// into cell index and fraction, and form the base voxel index of the cell.
// ----------------------------------------------------------------------------
module tvs_front
	import tvs_pkg::*;
#(
	parameter int MAX_DIM         = 64,
	parameter int COORD_FRAC_BITS = 8
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire cfg_t                 cfg,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic                 in_kind,
	input  wire logic [ADDR_IN_W-1:0] in_addr,
	input  wire logic [VAL_IN_W-1:0]  in_value,
	input  wire logic [CRD_W-1:0]     in_x,
	input  wire logic [CRD_W-1:0]     in_y,
	input  wire logic [CRD_W-1:0]     in_z,
	input  wire logic                 in_last,
	output logic                      cmd_valid,
	input  wire logic                 cmd_ready,
	output cmd_t                      cmd
);

	localparam int F          = COORD_FRAC_BITS;
	localparam int unsigned STORE_SIZE = MAX_DIM * MAX_DIM * MAX_DIM;
	localparam int LIM_W      = (F + DIM_W > CRD_W - 1) ? F + DIM_W : CRD_W - 1;
	localparam int P_W        = 2 * CRD_W + 1;
	localparam int ZL_W       = P_W - 1;
	localparam int ZF_W       = P_W - 1 - ZS_FRAC;
	localparam int ZA_W       = DIM_W + AREA_W;

	logic en1, en2, en3;

	// Stage 1: raw item.
	logic                 v_s1;
	logic                 kind_s1, last_s1;
	logic [ADDR_IN_W-1:0] addr_s1;
	logic [VAL_IN_W-1:0]  value_s1;
	logic [CRD_W-1:0]     x_s1, y_s1, z_s1;

	// Stage 2: z product, x/y tests, y row offset.
	logic                 v_s2;
	logic                 kind_s2, last_s2, xyout_s2;
	logic [ADDR_IN_W-1:0] addr_s2;
	logic [VAL_IN_W-1:0]  value_s2;
	logic signed [P_W-1:0] zprod_s2;
	logic [AREA_W-1:0]    yw_s2;
	logic [DIM_W-1:0]     xi_s2;
	logic [F-1:0]         fx_s2, fy_s2;

	// Stage 3: plane offset, full range test.
	logic                 v_s3;
	logic                 kind_s3, last_s3, out_s3;
	logic [ADDR_IN_W-1:0] addr_s3;
	logic [VAL_IN_W-1:0]  value_s3;
	logic [ZA_W-1:0]      za_s3;
	logic [AREA_W-1:0]    yw_s3;
	logic [DIM_W-1:0]     xi_s3;
	logic [F-1:0]         fx_s3, fy_s3, fz_s3;

	assign en3      = !v_s3 || cmd_ready;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	// ---- stage 1 ----
	always_ff @(posedge clk) begin
		if (en1) begin
			kind_s1  <= in_kind;
			last_s1  <= in_last;
			addr_s1  <= in_addr;
			value_s1 <= in_value;
			x_s1     <= in_x;
			y_s1     <= in_y;
			z_s1     <= in_z;
		end
	end

	logic signed [CRD_W-1:0] zs1;
	logic signed [ZS_W:0]    zsc;
	logic signed [P_W-1:0]   zprod;
	logic [DIM_W-1:0]        wm1, hm1;
	logic [LIM_W-1:0]        xlim, ylim;
	logic                    x_out, y_out;
	logic [31:0]             xe, ye;
	logic [DIM_W-1:0]        xi, yi;

	assign zs1   = $signed(z_s1);
	assign zsc   = $signed({1'b0, cfg.zscale});
	assign zprod = zs1 * zsc;

	assign wm1  = cfg.w - 7'd1;
	assign hm1  = cfg.h - 7'd1;
	assign xlim = LIM_W'(wm1) << F;
	assign ylim = LIM_W'(hm1) << F;

	// A zero dimension puts every point outside.
	assign x_out = (cfg.w == '0) || x_s1[CRD_W-1] || (LIM_W'(x_s1[CRD_W-2:0]) > xlim);
	assign y_out = (cfg.h == '0) || y_s1[CRD_W-1] || (LIM_W'(y_s1[CRD_W-2:0]) > ylim);

	assign xe = 32'(x_s1);
	assign ye = 32'(y_s1);
	assign xi = xe[F +: DIM_W];
	assign yi = ye[F +: DIM_W];

	always_ff @(posedge clk) begin
		if (en2) begin
			kind_s2  <= kind_s1;
			last_s2  <= last_s1;
			addr_s2  <= addr_s1;
			value_s2 <= value_s1;
			xyout_s2 <= x_out || y_out;
			zprod_s2 <= zprod;
			yw_s2    <= yi * cfg.w;
			xi_s2    <= xi;
			fx_s2    <= x_s1[F-1:0];
			fy_s2    <= y_s1[F-1:0];
		end
	end

	// ---- stage 2 ----
	logic [DIM_W-1:0] dm1;
	logic [ZL_W-1:0]  zlim;
	logic             z_out;
	logic [ZF_W-1:0]  zf;
	logic [31:0]      zfe;
	logic [DIM_W-1:0] zi;

	assign dm1   = cfg.d - 7'd1;
	assign zlim  = ZL_W'(dm1) << (F + ZS_FRAC);
	// Negative and overflowing products both land outside.
	assign z_out = (cfg.d == '0) || zprod_s2[P_W-1] || (zprod_s2[P_W-2:0] > zlim);
	assign zf    = zprod_s2[P_W-2:ZS_FRAC];
	assign zfe   = 32'(zf);
	assign zi    = zfe[F +: DIM_W];

	always_ff @(posedge clk) begin
		if (en3) begin
			kind_s3  <= kind_s2;
			last_s3  <= last_s2;
			addr_s3  <= addr_s2;
			value_s3 <= value_s2;
			out_s3   <= xyout_s2 || z_out;
			za_s3    <= zi * cfg.area;
			yw_s3    <= yw_s2;
			xi_s3    <= xi_s2;
			fx_s3    <= fx_s2;
			fy_s3    <= fy_s2;
			fz_s3    <= zf[F-1:0];
		end
	end

	// ---- stage 3: base index of the cell, or the write address ----
	logic [MAX_IDX_W-1:0] base;
	logic [31:0]          addr_ext;

	assign base     = MAX_IDX_W'(za_s3) + MAX_IDX_W'(yw_s3) + MAX_IDX_W'(xi_s3);
	assign addr_ext = 32'(addr_s3);

	assign cmd_valid   = v_s3;
	assign cmd.kind    = kind_s3;
	assign cmd.wr_ok   = addr_ext < STORE_SIZE;
	assign cmd.outside = out_s3;
	assign cmd.last    = last_s3;
	assign cmd.idx     = (kind_s3 == OP_SAMPLE) ? base : MAX_IDX_W'(addr_s3);
	assign cmd.value   = value_s3;
	assign cmd.fx      = MAX_FRAC_W'(fx_s3);
	assign cmd.fy      = MAX_FRAC_W'(fy_s3);
	assign cmd.fz      = MAX_FRAC_W'(fz_s3);

endmodule
`default_nettype wire

/* rtl/core/tvs_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tvs_queue: command queue between front end and back end
// A small register FIFO so that either side can stall without the other.
// ----------------------------------------------------------------------------
module tvs_queue
	import tvs_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire cmd_t in_cmd,
	output logic      out_valid,
	input  wire logic out_ready,
	output cmd_t      out_cmd
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	cmd_t             entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]   count_q;
	logic             push, pop;

	assign in_ready  = count_q != (PTR_W + 1)'(QUEUE_DEPTH);
	assign out_valid = count_q != '0;
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_cmd   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= in_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

endmodule
`default_nettype wire

/* rtl/core/tvs_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tvs_back: voxel store and interpolation engine
// Executes writes into the single-port voxel memory and, for samples, walks
// the eight cell corners through a read and multiply-accumulate pipeline.
// ----------------------------------------------------------------------------
module tvs_back
	import tvs_pkg::*;
#(
	parameter int MAX_DIM         = 64,
	parameter int COORD_FRAC_BITS = 8,
	parameter int VOXEL_BITS      = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cfg_t             cfg,
	input  wire logic             cmd_valid,
	output logic                  cmd_ready,
	input  wire cmd_t             cmd,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [OUT_W-1:0]      out_value,
	output logic                  out_flag,
	output logic                  out_last
);

	localparam int F          = COORD_FRAC_BITS;
	localparam int V          = VOXEL_BITS;
	localparam int STORE_SIZE = MAX_DIM * MAX_DIM * MAX_DIM;
	localparam int IDX_W      = $clog2(STORE_SIZE);
	localparam int W_W        = F + 1;
	localparam int ACC_W      = 3 * F + 16;
	localparam int SHIFT      = 3 * F - OUT_FRAC;
	localparam logic [W_W-1:0] ONE = {1'b1, {F{1'b0}}};

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_EMIT  = 2'd3;

	logic [1:0] state_q;
	cmd_t       cur_q;
	logic [2:0] nb_q;

	logic [V-1:0] mem [STORE_SIZE];
	logic [V-1:0] rd_q;

	logic             v_s1, v_s2, v_s3;
	logic [2*W_W-1:0] wxy_s1;
	logic [W_W-1:0]   wz_s1;
	logic [3*W_W-1:0] wt_s2;
	logic [V-1:0]     vox_s2;
	logic [3*W_W+V-1:0] prod_s3;
	logic [ACC_W-1:0] acc_q;

	logic             take, emit;
	logic             wr_en, rd_en, nz;
	logic [F-1:0]     fx, fy, fz;
	logic [W_W-1:0]   wx, wy, wz;
	logic [IDX_W-1:0] off, rd_addr;

	assign cmd_ready = state_q == ST_IDLE;
	assign take      = cmd_valid && cmd_ready;
	assign emit      = (state_q == ST_EMIT) && (!out_valid || out_ready);
	assign wr_en     = take && (cmd.kind == OP_WRITE) && cmd.wr_ok;

	// Corner weights: bit 0 of the corner count picks x, bit 1 y, bit 2 z.
	assign fx = cur_q.fx[F-1:0];
	assign fy = cur_q.fy[F-1:0];
	assign fz = cur_q.fz[F-1:0];
	assign wx = nb_q[0] ? {1'b0, fx} : ONE - {1'b0, fx};
	assign wy = nb_q[1] ? {1'b0, fy} : ONE - {1'b0, fy};
	assign wz = nb_q[2] ? {1'b0, fz} : ONE - {1'b0, fz};

	// A far corner only carries weight when its fraction is nonzero.
	assign nz = (!nb_q[0] || fx != '0) && (!nb_q[1] || fy != '0) && (!nb_q[2] || fz != '0);
	assign rd_en = (state_q == ST_RUN) && nz;

	assign off = IDX_W'(nb_q[0])
		+ (nb_q[1] ? IDX_W'(cfg.w) : '0)
		+ (nb_q[2] ? IDX_W'(cfg.area) : '0);
	assign rd_addr = cur_q.idx[IDX_W-1:0] + off;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[cmd.idx[IDX_W-1:0]] <= cmd.value[V-1:0];
		end else if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			nb_q      <= '0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			v_s1 <= rd_en;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (emit) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (take && cmd.kind == OP_SAMPLE) begin
						nb_q    <= '0;
						state_q <= cmd.outside ? ST_EMIT : ST_RUN;
					end
				end
				ST_RUN: begin
					nb_q <= nb_q + 3'd1;
					if (nb_q == 3'd7) state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					if (!v_s1 && !v_s2 && !v_s3) state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) cur_q <= cmd;
		wxy_s1  <= wx * wy;
		wz_s1   <= wz;
		wt_s2   <= wxy_s1 * wz_s1;
		vox_s2  <= rd_q;
		prod_s3 <= wt_s2 * vox_s2;
		if (take) acc_q <= '0;
		else if (v_s3) acc_q <= acc_q + ACC_W'(prod_s3);
		if (emit) begin
			out_value <= cur_q.outside ? '0 : acc_q[SHIFT +: OUT_W];
			out_flag  <= cur_q.outside;
			out_last  <= cur_q.last;
		end
	end

endmodule
`default_nettype wire

/* rtl/core/trilinear_volume_sampler.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trilinear_volume_sampler: 3D voxel store with trilinear point sampling
// Top level: configuration registers, front end, command queue, back end.
// ----------------------------------------------------------------------------
// Usage. Words arrive on the s_ group. s_tuser selects the operation: a write
// stores the voxel value at the linear address, a sample asks for the
// trilinear interpolation at point (x, y, z), z being scaled by z_scale first.
// Writes produce no output word; each sample produces exactly one word on the
// m_ group, in order, with out_of_range on m_tuser and the batch mark on tlast.
// In flight, a word passes the front-end stages and is registered in the
// command queue. In the back end a write is done when it is taken; an
// outside sample is taken and loads the output register; an inside sample
// is taken, steps the eight corners through the single-port voxel memory,
// drains the read and multiply pipeline (sooner when the last corners carry
// no weight), and loads the output register. The corner walk over that one
// memory port sets the sample rate.
// Reset clears all control state and loads the register defaults; the voxel
// memory is not cleared and a voxel must be written before it is sampled.
// When m_tready is low the output word holds; the back end waits with its
// next result while the queue and the front end keep taking words until full.
// Configuration writes are taken at any cycle and should only be issued while
// no word is in flight.
// ----------------------------------------------------------------------------
module trilinear_volume_sampler
	import tvs_pkg::*;
#(
	parameter int MAX_DIM         = 64,
	parameter int COORD_FRAC_BITS = 8,
	parameter int VOXEL_BITS      = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// Configuration write port.
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	// Input stream.
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// tdata: voxel_address[17:0], voxel_value[33:18], x_coord[49:34],
	//        y_coord[65:50], z_coord[81:66], zero fill[87:82]
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	// tuser: opcode
	input  wire logic                  s_tuser,
	input  wire logic                  s_tlast,
	// Output stream.
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// tdata: sample_value[23:0]
	output logic [OUT_W-1:0]           m_tdata,
	// tuser: out_of_range
	output logic                       m_tuser,
	output logic                       m_tlast
);

	// Dimension registers above MAX_DIM act as MAX_DIM.
	localparam logic [DIM_W-1:0] DIM_CAP = (MAX_DIM > 127) ? 7'd127 : 7'(MAX_DIM);

	logic [DIM_W-1:0]  vol_width_q, vol_height_q, vol_depth_q;
	logic [ZS_W-1:0]   z_scale_q;
	logic [AREA_W-1:0] area_q;
	logic [DIM_W-1:0]  w_eff, h_eff, d_eff;
	cfg_t              cfg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vol_width_q  <= RST_DIM;
			vol_height_q <= RST_DIM;
			vol_depth_q  <= RST_DIM;
			z_scale_q    <= RST_Z_SCALE;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_VOL_WIDTH:  vol_width_q  <= cfg_data[DIM_W-1:0];
				REG_VOL_HEIGHT: vol_height_q <= cfg_data[DIM_W-1:0];
				REG_VOL_DEPTH:  vol_depth_q  <= cfg_data[DIM_W-1:0];
				REG_Z_SCALE:    z_scale_q    <= cfg_data[ZS_W-1:0];
				default: ;
			endcase
		end
	end

	assign w_eff = (32'(vol_width_q)  > 32'(MAX_DIM)) ? DIM_CAP : vol_width_q;
	assign h_eff = (32'(vol_height_q) > 32'(MAX_DIM)) ? DIM_CAP : vol_height_q;
	assign d_eff = (32'(vol_depth_q)  > 32'(MAX_DIM)) ? DIM_CAP : vol_depth_q;

	// The plane size is registered; it settles in the cycle after a write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			area_q <= '0;
		end else begin
			area_q <= w_eff * h_eff;
		end
	end

	assign cfg.w      = w_eff;
	assign cfg.h      = h_eff;
	assign cfg.d      = d_eff;
	assign cfg.zscale = z_scale_q;
	assign cfg.area   = area_q;

	logic fq_valid, fq_ready, qb_valid, qb_ready;
	cmd_t fq_cmd, qb_cmd;

	tvs_front #(
		.MAX_DIM         (MAX_DIM),
		.COORD_FRAC_BITS (COORD_FRAC_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_kind   (s_tuser),
		.in_addr   (s_tdata[17:0]),
		.in_value  (s_tdata[33:18]),
		.in_x      (s_tdata[49:34]),
		.in_y      (s_tdata[65:50]),
		.in_z      (s_tdata[81:66]),
		.in_last   (s_tlast),
		.cmd_valid (fq_valid),
		.cmd_ready (fq_ready),
		.cmd       (fq_cmd)
	);

	tvs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fq_valid),
		.in_ready  (fq_ready),
		.in_cmd    (fq_cmd),
		.out_valid (qb_valid),
		.out_ready (qb_ready),
		.out_cmd   (qb_cmd)
	);

	tvs_back #(
		.MAX_DIM         (MAX_DIM),
		.COORD_FRAC_BITS (COORD_FRAC_BITS),
		.VOXEL_BITS      (VOXEL_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd_valid (qb_valid),
		.cmd_ready (qb_ready),
		.cmd       (qb_cmd),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_value (m_tdata),
		.out_flag  (m_tuser),
		.out_last  (m_tlast)
	);

endmodule
`default_nettype wire

/* rtl/core/tvs_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tvs_checker: port-level checks of the volume sampler
// Watches the stream ports and checks output hold, pending samples and value bounds.
// ----------------------------------------------------------------------------
module tvs_checker
	import tvs_pkg::*;
#(
	parameter int VOXEL_BITS = 16
) (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             s_tvalid,
	input wire logic             s_tready,
	input wire logic             s_tuser,
	input wire logic             m_tvalid,
	input wire logic             m_tready,
	input wire logic [OUT_W-1:0] m_tdata,
	input wire logic             m_tuser,
	input wire logic             m_tlast
);

	localparam logic [OUT_W-1:0] VAL_MAX = OUT_W'(((1 << VOXEL_BITS) - 1) << OUT_FRAC);

	// Samples taken in whose result has not been delivered yet.
	logic [4:0] pend_q;
	logic       s_smp, m_acc;

	assign s_smp = s_tvalid && s_tready && (s_tuser == OP_SAMPLE);
	assign m_acc = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (s_smp && !m_acc) begin
			pend_q <= pend_q + 5'd1;
		end else if (m_acc && !s_smp) begin
			pend_q <= pend_q - 5'd1;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("output word changed while stalled");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		m_acc |-> pend_q != '0)
		else $error("result delivered without a pending sample");

	a_flag_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("out of range result carries a nonzero value");

	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata <= VAL_MAX)
		else $error("interpolated value above the voxel range");

endmodule

bind trilinear_volume_sampler tvs_checker #(
	.VOXEL_BITS (VOXEL_BITS)
) u_tvs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
`default_nettype wire
